>>> rtl/ortt_pkg.sv
// Shared types and constants for the outstanding request tag table.
package ortt_pkg;

   // Default table geometry.
   localparam int ORTT_TABLE_DEPTH = 16;
   localparam int ORTT_HANDLE_BITS = 16;

   // Fixed widths of the transaction fields.
   localparam int ORTT_TAG_W    = 32;
   localparam int ORTT_HANDLE_W = 16;

   // A drain moves at most this many entries out per command.
   localparam int ORTT_MAX_RESULTS = 16;
   localparam int ORTT_DRAIN_CNT_W = $clog2(ORTT_MAX_RESULTS);

   // Command codes.
   typedef enum logic [1:0] {
      CMD_STORE = 2'd0,
      CMD_FETCH = 2'd1,
      CMD_DRAIN = 2'd2
   } command_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_EMPTY     = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY,
      ST_DRAIN
   } state_type;

   // Operation broadcast to every cell of the chain.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_COMPARE,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_SHIFT
   } cell_op_type;

   // Request transaction payload.
   typedef struct packed {
      logic [1:0]              command;
      logic [ORTT_TAG_W-1:0]    tag_id;
      logic [ORTT_HANDLE_W-1:0] handle_in;
      logic [ORTT_TAG_W-1:0]    restore_in;
      logic                    routable_in;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [2:0]              status;
      logic [ORTT_TAG_W-1:0]    tag_out;
      logic [ORTT_HANDLE_W-1:0] handle_out;
      logic [ORTT_TAG_W-1:0]    restore_out;
      logic                    requeue;
      logic                    last;
   } rsp_type;

   // Table entry fields of fixed width; the handle travels beside it.
   typedef struct packed {
      logic [ORTT_TAG_W-1:0] tag;
      logic [ORTT_TAG_W-1:0] restore;
      logic                 routable;
   } entry_type;

   // Control broadcast from the controller to the cells.
   typedef struct packed {
      cell_op_type op;
      entry_type   key;
   } cell_ctrl_type;

endpackage

>>> rtl/outstanding_request_tag_table.sv
// Outstanding request table kept sorted by tag in a chain of cells. Store and fetch each
// pass through a compare state, in which every cell compares its tag with the request, then
// an apply state, in which the chain shifts to insert or close the gap and the response is
// registered; the next request is accepted in the apply state once the response register is
// free. A drain moves one entry out of the head cell per cycle, up to 16 per command, slower
// only when the response side stalls. The response register lets a response wait while the
// next request is accepted.
module outstanding_request_tag_table
   import ortt_pkg::*;
#(
   parameter int TABLE_DEPTH = ORTT_TABLE_DEPTH,
   parameter int HANDLE_BITS = ORTT_HANDLE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [ORTT_DRAIN_CNT_W-1:0] drain_cnt_ff, drain_cnt_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   cell_ctrl_type          cell_ctrl;
   logic [HANDLE_BITS-1:0] key_handle;
   entry_type              cell_entry [TABLE_DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_valid;
   logic [TABLE_DEPTH-1:0] cell_less;
   logic [TABLE_DEPTH-1:0] cell_match;

   logic                   out_free;
   logic                   req_accept;
   logic                   found;
   logic                   table_full;
   logic                   drain_last;
   logic                   rsp_load;
   rsp_type                rsp_next;
   entry_type              sel_entry;
   logic [HANDLE_BITS-1:0] sel_handle;
   state_type              dispatch_state;

   // Handshake terms.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_APPLY) && out_free));
   assign req_accept = req_valid && !req_stall;

   // Table-wide flags from the compare cycle, and the drain end flag.
   assign found      = |cell_match;
   assign table_full = cell_valid[TABLE_DEPTH-1];
   assign drain_last = drain_cnt_ff == ORTT_DRAIN_CNT_W'(ORTT_MAX_RESULTS - 1);

   // Entry that matched, gathered from the one-hot match flags.
   always_comb begin
      sel_entry  = '0;
      sel_handle = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cell_match[i]) begin
            sel_entry  = sel_entry | cell_entry[i];
            sel_handle = sel_handle | cell_handle[i];
         end
      end
   end

   // State a newly accepted transaction starts in.
   always_comb begin
      unique case (req_data.command)
         CMD_STORE, CMD_FETCH: dispatch_state = ST_COMPARE;
         CMD_DRAIN:            dispatch_state = ST_DRAIN;
         default:              dispatch_state = ST_IDLE;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = dispatch_state;
         end
         ST_COMPARE: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (req_accept)    state_in = dispatch_state;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_DRAIN: begin
            if (out_free && (!cell_valid[0] || !cell_valid[1] || drain_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Cell control and response for the current state.
   always_comb begin
      cell_ctrl.op  = CELL_HOLD;
      cell_ctrl.key = '{tag: req_ff.tag_id, restore: req_ff.restore_in,
                        routable: req_ff.routable_in};
      key_handle    = HANDLE_BITS'(req_ff.handle_in);
      rsp_load      = 1'b0;
      rsp_next      = '0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_COMPARE: begin
            cell_ctrl.op = CELL_COMPARE;
         end
         ST_APPLY: begin
            rsp_load      = out_free;
            rsp_next.last = 1'b1;
            if (req_ff.command == CMD_STORE) begin
               rsp_next.tag_out     = req_ff.tag_id;
               rsp_next.handle_out  = ORTT_HANDLE_W'(key_handle);
               rsp_next.restore_out = req_ff.restore_in;
               if (found) begin
                  rsp_next.status = STATUS_DUPLICATE;
               end else if (table_full) begin
                  rsp_next.status = STATUS_FULL;
               end else begin
                  rsp_next.status = STATUS_OK;
                  if (out_free) cell_ctrl.op = CELL_INSERT;
               end
            end else if (found) begin
               rsp_next.status      = STATUS_OK;
               rsp_next.tag_out     = sel_entry.tag;
               rsp_next.handle_out  = ORTT_HANDLE_W'(sel_handle);
               rsp_next.restore_out = sel_entry.restore;
               if (out_free) cell_ctrl.op = CELL_REMOVE;
            end else begin
               rsp_next.status  = STATUS_NOT_FOUND;
               rsp_next.tag_out = req_ff.tag_id;
            end
         end
         ST_DRAIN: begin
            rsp_load = out_free;
            if (cell_valid[0]) begin
               rsp_next.status      = STATUS_OK;
               rsp_next.tag_out     = cell_entry[0].tag;
               rsp_next.handle_out  = ORTT_HANDLE_W'(cell_handle[0]);
               rsp_next.restore_out = cell_entry[0].restore;
               rsp_next.requeue     = cell_entry[0].routable;
               rsp_next.last        = !cell_valid[1];
               if (out_free) cell_ctrl.op = CELL_SHIFT;
            end else begin
               rsp_next.status = STATUS_EMPTY;
               rsp_next.last   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Request capture, drain count and response register.
   always_comb begin
      req_in       = req_accept ? req_data : req_ff;
      drain_cnt_in = drain_cnt_ff;
      if (req_accept) begin
         drain_cnt_in = '0;
      end else if ((state_ff == ST_DRAIN) && out_free) begin
         drain_cnt_in = drain_cnt_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         drain_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         drain_cnt_ff <= drain_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The chain of table cells, slot 0 holding the lowest tag.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type              left_entry, right_entry;
      logic [HANDLE_BITS-1:0] left_handle, right_handle;
      logic                   left_valid, left_less, right_valid;

      if (i == 0) begin : g_head
         assign left_entry  = cell_ctrl.key;
         assign left_handle = key_handle;
         assign left_valid  = 1'b1;
         assign left_less   = 1'b0;
      end else begin : g_body
         assign left_entry  = cell_entry[i-1];
         assign left_handle = cell_handle[i-1];
         assign left_valid  = cell_valid[i-1];
         assign left_less   = cell_less[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_entry  = '0;
         assign right_handle = '0;
         assign right_valid  = 1'b0;
      end else begin : g_inner
         assign right_entry  = cell_entry[i+1];
         assign right_handle = cell_handle[i+1];
         assign right_valid  = cell_valid[i+1];
      end

      ortt_cell #(
         .HANDLE_BITS(HANDLE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .key_handle   (key_handle),
         .left_entry   (left_entry),
         .left_handle  (left_handle),
         .left_valid   (left_valid),
         .left_less    (left_less),
         .right_entry  (right_entry),
         .right_handle (right_handle),
         .right_valid  (right_valid),
         .entry        (cell_entry[i]),
         .handle       (cell_handle[i]),
         .valid        (cell_valid[i]),
         .less         (cell_less[i]),
         .match        (cell_match[i])
      );
   end

   // Valid slots always form a prefix of the chain.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, cell_valid} & ({1'b0, cell_valid} + 1'b1)) == '0))
      else $error("table valid bits are not compacted");

   // Tags are unique, so at most one cell matches and never one below the key.
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_match) && ((cell_match & cell_less) == '0))
      else $error("inconsistent compare flags");

   // A successful fetch removes exactly one entry.
   a_fetch_removes_one: assert property (@(posedge clock) disable iff (reset)
      (cell_ctrl.op == CELL_REMOVE) |=>
         ($countones(cell_valid) == $past($countones(cell_valid)) - 1))
      else $error("fetch did not remove exactly one entry");

   // A store that is inserted adds exactly one entry.
   a_store_adds_one: assert property (@(posedge clock) disable iff (reset)
      (cell_ctrl.op == CELL_INSERT) |=>
         ($countones(cell_valid) == $past($countones(cell_valid)) + 1))
      else $error("store did not add exactly one entry");

endmodule

>>> rtl/ortt_cell.sv
// One slot of the sorted tag chain, exchanging entries with its neighbors.
module ortt_cell
   import ortt_pkg::*;
#(
   parameter int HANDLE_BITS = ORTT_HANDLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [HANDLE_BITS-1:0] key_handle,
   input  entry_type              left_entry,
   input  logic [HANDLE_BITS-1:0] left_handle,
   input  logic                   left_valid,
   input  logic                   left_less,
   input  entry_type              right_entry,
   input  logic [HANDLE_BITS-1:0] right_handle,
   input  logic                   right_valid,
   output entry_type              entry,
   output logic [HANDLE_BITS-1:0] handle,
   output logic                   valid,
   output logic                   less,
   output logic                   match
);

   logic                   valid_ff, valid_in;
   logic                   less_ff, less_in;
   logic                   match_ff, match_in;
   entry_type              entry_ff, entry_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;

   // Compare against the key, or move entries along the chain.
   always_comb begin
      valid_in  = valid_ff;
      less_in   = less_ff;
      match_in  = match_ff;
      entry_in  = entry_ff;
      handle_in = handle_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_COMPARE: begin
            less_in  = valid_ff && (entry_ff.tag < ctrl.key.tag);
            match_in = valid_ff && (entry_ff.tag == ctrl.key.tag);
         end
         CELL_INSERT: begin
            // Slots above the insertion point take their left neighbor.
            if (!less_ff) begin
               valid_in = left_valid;
               if (left_less) begin
                  entry_in  = ctrl.key;
                  handle_in = key_handle;
               end else begin
                  entry_in  = left_entry;
                  handle_in = left_handle;
               end
            end
         end
         CELL_REMOVE: begin
            // Slots from the match upward close the gap.
            if (!less_ff) begin
               valid_in  = right_valid;
               entry_in  = right_entry;
               handle_in = right_handle;
            end
         end
         CELL_SHIFT: begin
            valid_in  = right_valid;
            entry_in  = right_entry;
            handle_in = right_handle;
         end
         default: begin
         end
      endcase
   end

   // Control flags under reset, payload without.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         less_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         less_ff  <= less_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      handle_ff <= handle_in;
   end

   assign entry  = entry_ff;
   assign handle = handle_ff;
   assign valid  = valid_ff;
   assign less   = less_ff;
   assign match  = match_ff;

endmodule
